[hdl/rcmb_pkg.sv]
// ----------------------------------------------------------------------------
// rcmb_pkg
// Shared types and constants for the recursive cross-core mutex bank.
// ----------------------------------------------------------------------------
package rcmb_pkg;

   localparam int NUM_MUTEXES    = 8;
   localparam int NUM_CORES      = 2;
   localparam int THREAD_ID_BITS = 8;
   localparam int MAX_DEPTH      = 255;

   // fixed widths of the request and response fields
   localparam int OP_W     = 2;
   localparam int IDX_W    = 3;
   localparam int CORE_W   = 1;
   localparam int THREAD_W = 8;
   localparam int STATUS_W = 3;
   localparam int DEPTH_OUT_W   = 8;
   localparam int WAITERS_OUT_W = 2;

   // storage widths
   localparam int MUTEX_IDX_W = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
   localparam int DEPTH_W     = $clog2(MAX_DEPTH + 1);

   typedef enum logic [OP_W-1:0] {
      OP_LOCK    = 2'd0,
      OP_UNLOCK  = 2'd1,
      OP_ABANDON = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_NEW_GRANT = 3'd0,
      ST_RECURSIVE = 3'd1,
      ST_BUSY      = 3'd2,
      ST_FREED     = 3'd3,
      ST_LOWERED   = 3'd4,
      ST_NOT_OWNER = 3'd5,
      ST_ABANDONED = 3'd6,
      ST_SATURATED = 3'd7
   } status_type;

   typedef struct packed {
      logic                      owned;
      logic [CORE_W-1:0]         core;
      logic [THREAD_ID_BITS-1:0] thread;
      logic [DEPTH_W-1:0]        depth;
      logic [NUM_CORES-1:0]      waiting;
   } entry_type;

   typedef struct packed {
      logic                   en;
      logic [MUTEX_IDX_W-1:0] idx;
      entry_type              entry;
   } bank_wr_type;

   typedef struct packed {
      logic                     granted;
      status_type               status;
      logic [DEPTH_OUT_W-1:0]   depth;
      logic [CORE_W-1:0]        holder_core;
      logic                     held;
      logic [WAITERS_OUT_W-1:0] waiters;
   } rsp_type;

endpackage

[hdl/rcmb_bank.sv]
// ----------------------------------------------------------------------------
// rcmb_bank
// Per-mutex state registers: owner, recursion count and waiting-core mask.
// ----------------------------------------------------------------------------
module rcmb_bank (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [rcmb_pkg::MUTEX_IDX_W-1:0]  rd_idx,
   output rcmb_pkg::entry_type               rd_entry,
   input  rcmb_pkg::bank_wr_type             wr
);

   rcmb_pkg::entry_type bank_ff [rcmb_pkg::NUM_MUTEXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rcmb_pkg::NUM_MUTEXES; i++) begin
            bank_ff[i] <= '0;
         end
      end else if (wr.en) begin
         bank_ff[wr.idx] <= wr.entry;
      end
   end

   assign rd_entry = bank_ff[rd_idx];

endmodule

[hdl/rcmb_step.sv]
// ----------------------------------------------------------------------------
// rcmb_step
// Next-state and response logic for one request against one mutex entry.
// ----------------------------------------------------------------------------
module rcmb_step (
   input  logic [rcmb_pkg::OP_W-1:0]        op,
   input  logic [rcmb_pkg::IDX_W-1:0]       idx,
   input  logic [rcmb_pkg::CORE_W-1:0]      core,
   input  logic [rcmb_pkg::THREAD_W-1:0]    thread,
   input  rcmb_pkg::entry_type              cur,
   output logic [rcmb_pkg::MUTEX_IDX_W-1:0] rd_idx,
   output rcmb_pkg::bank_wr_type            wr,
   output rcmb_pkg::rsp_type                rsp
);

   logic                                    in_range;
   logic [rcmb_pkg::THREAD_ID_BITS-1:0]     tid;
   logic [rcmb_pkg::NUM_CORES-1:0]          bit_mask;
   logic                                    mine;
   logic                                    mine_after;
   rcmb_pkg::entry_type                     nxt;
   rcmb_pkg::status_type                    status;

   assign in_range = (32'(idx) < rcmb_pkg::NUM_MUTEXES);
   assign rd_idx   = rcmb_pkg::MUTEX_IDX_W'(idx);
   assign tid      = rcmb_pkg::THREAD_ID_BITS'(thread);

   // a core outside the core count has no waiting bit
   assign bit_mask = (32'(core) < rcmb_pkg::NUM_CORES) ?
                     (rcmb_pkg::NUM_CORES'(1) << core) : '0;

   assign mine = cur.owned && (cur.core == core) && (cur.thread == tid);

   always_comb begin
      nxt    = cur;
      status = rcmb_pkg::ST_NOT_OWNER;
      case (op)
         rcmb_pkg::OP_LOCK: begin
            if (mine) begin
               if (cur.depth >= rcmb_pkg::DEPTH_W'(rcmb_pkg::MAX_DEPTH)) begin
                  status = rcmb_pkg::ST_SATURATED;
               end else begin
                  nxt.depth = cur.depth + rcmb_pkg::DEPTH_W'(1);
                  status    = rcmb_pkg::ST_RECURSIVE;
               end
            end else if (!cur.owned) begin
               nxt.owned   = 1'b1;
               nxt.core    = core;
               nxt.thread  = tid;
               nxt.depth   = rcmb_pkg::DEPTH_W'(1);
               nxt.waiting = cur.waiting & ~bit_mask;
               status      = rcmb_pkg::ST_NEW_GRANT;
            end else begin
               nxt.waiting = cur.waiting | bit_mask;
               status      = rcmb_pkg::ST_BUSY;
            end
         end
         rcmb_pkg::OP_UNLOCK: begin
            if (mine) begin
               if (cur.depth > rcmb_pkg::DEPTH_W'(1)) begin
                  nxt.depth = cur.depth - rcmb_pkg::DEPTH_W'(1);
                  status    = rcmb_pkg::ST_LOWERED;
               end else begin
                  // waiting mask is kept so software sees whom to signal
                  nxt.owned  = 1'b0;
                  nxt.core   = '0;
                  nxt.thread = '0;
                  nxt.depth  = '0;
                  status     = rcmb_pkg::ST_FREED;
               end
            end
         end
         rcmb_pkg::OP_ABANDON: begin
            nxt.waiting = cur.waiting & ~bit_mask;
            status      = rcmb_pkg::ST_ABANDONED;
         end
         default: begin
            status = rcmb_pkg::ST_NOT_OWNER;
         end
      endcase
   end

   assign mine_after = nxt.owned && (nxt.core == core) && (nxt.thread == tid);

   always_comb begin
      wr.en    = in_range;
      wr.idx   = rd_idx;
      wr.entry = nxt;
      if (in_range) begin
         rsp.granted     = mine_after;
         rsp.status      = status;
         rsp.depth       = rcmb_pkg::DEPTH_OUT_W'(nxt.depth);
         rsp.holder_core = nxt.owned ? nxt.core : '0;
         rsp.held        = nxt.owned;
         rsp.waiters     = rcmb_pkg::WAITERS_OUT_W'(nxt.waiting);
      end else begin
         rsp        = '0;
         rsp.status = rcmb_pkg::ST_NOT_OWNER;
      end
   end

endmodule

[hdl/recursive_cross_core_mutex_bank.sv]
// ----------------------------------------------------------------------------
// recursive_cross_core_mutex_bank
// Bank of recursive mutexes shared between cores, one atomic step per request.
// ----------------------------------------------------------------------------
// Takes one request per clock when not stalled and returns exactly one
// response per request, in order. A request is captured in the input
// register, then the addressed mutex entry is read, updated and written back
// while the response is loaded into the output register. The single
// read-modify-write of one entry per cycle sets the rate, so back to back
// requests to the same mutex see each other's updates with no bubble.
// A stalled response holds the pipeline; the input side stalls only when
// both the input and output registers are full.
module recursive_cross_core_mutex_bank (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [rcmb_pkg::OP_W-1:0]        req_op,
   input  logic [rcmb_pkg::IDX_W-1:0]       req_mutex_index,
   input  logic [rcmb_pkg::CORE_W-1:0]      req_requester_core,
   input  logic [rcmb_pkg::THREAD_W-1:0]    req_requester_thread,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_granted,
   output logic [rcmb_pkg::STATUS_W-1:0]    rsp_status,
   output logic [rcmb_pkg::DEPTH_OUT_W-1:0] rsp_depth,
   output logic [rcmb_pkg::CORE_W-1:0]      rsp_holder_core,
   output logic                             rsp_held,
   output logic [rcmb_pkg::WAITERS_OUT_W-1:0] rsp_waiters
);

   logic                              s1_valid_ff, s1_valid_in;
   logic [rcmb_pkg::OP_W-1:0]         s1_op_ff;
   logic [rcmb_pkg::IDX_W-1:0]        s1_idx_ff;
   logic [rcmb_pkg::CORE_W-1:0]       s1_core_ff;
   logic [rcmb_pkg::THREAD_W-1:0]     s1_thread_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   rcmb_pkg::rsp_type                 rsp_ff;
   rcmb_pkg::rsp_type                 step_rsp;
   rcmb_pkg::bank_wr_type             step_wr;
   rcmb_pkg::bank_wr_type             bank_wr;
   rcmb_pkg::entry_type               cur_entry;
   logic [rcmb_pkg::MUTEX_IDX_W-1:0]  rd_idx;
   logic                              advance;
   logic                              req_take;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff     <= req_op;
         s1_idx_ff    <= req_mutex_index;
         s1_core_ff   <= req_requester_core;
         s1_thread_ff <= req_requester_thread;
      end
      if (advance && s1_valid_ff) begin
         rsp_ff <= step_rsp;
      end
   end

   rcmb_step u_step (
      .op     (s1_op_ff),
      .idx    (s1_idx_ff),
      .core   (s1_core_ff),
      .thread (s1_thread_ff),
      .cur    (cur_entry),
      .rd_idx (rd_idx),
      .wr     (step_wr),
      .rsp    (step_rsp)
   );

   // commit the entry only when the transaction moves into the output register
   always_comb begin
      bank_wr    = step_wr;
      bank_wr.en = step_wr.en && s1_valid_ff && advance;
   end

   rcmb_bank u_bank (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (rd_idx),
      .rd_entry (cur_entry),
      .wr       (bank_wr)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_granted     = rsp_ff.granted;
   assign rsp_status      = rsp_ff.status;
   assign rsp_depth       = rsp_ff.depth;
   assign rsp_holder_core = rsp_ff.holder_core;
   assign rsp_held        = rsp_ff.held;
   assign rsp_waiters     = rsp_ff.waiters;

   a_granted_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted |-> rsp_held)
      else $error("granted response without an owner");

   a_free_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_held |-> (rsp_depth == '0) && (rsp_holder_core == '0))
      else $error("free mutex reports depth or holder");

   a_new_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == rcmb_pkg::ST_NEW_GRANT) |->
         rsp_granted && (rsp_depth == rcmb_pkg::DEPTH_OUT_W'(1)))
      else $error("new grant without count of one");

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_valid_ff)
      else $error("accepted transaction lost in input register");

endmodule
